// ----- src/vfd_pkg.sv -----
`default_nettype none

package vfd_pkg;

    // Frame geometry
    localparam int DIGIT_COUNT = 6;
    localparam int DIGIT_BITS  = 12;

    // Field widths
    localparam int VALUE_W = 20;
    localparam int MODE_W  = 2;
    localparam int FRAME_W = 12;
    localparam int LEN_W   = 4;
    localparam int ENTRY_W = 4;

    // Digit counter width inside one frame
    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Divide by ten through a scaled reciprocal, exact for any VALUE_W-bit value
    localparam int RECIP_SHIFT = VALUE_W + 3;
    localparam int RECIP_W     = VALUE_W;
    localparam int PROD_W      = VALUE_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10 + 64'd1);

    // Table entry codes and word lengths
    localparam logic [ENTRY_W-1:0] BLANK_ENTRY    = 4'd10;
    localparam logic [LEN_W-1:0]   WORD_LEN_MODE  = 4'd2;
    localparam logic [LEN_W-1:0]   WORD_LEN_DIGIT = LEN_W'(DIGIT_BITS);
    localparam logic [15:0]        DIGIT_MASK     = 16'((32'd1 << DIGIT_BITS) - 32'd1);

    typedef struct packed {
        logic [VALUE_W-1:0] display_value;
        logic [MODE_W-1:0]  mode_code;
        logic               blank;
    } vfd_in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_word;
        logic [LEN_W-1:0]   word_length;
        logic               last_word;
    } vfd_out_t;

    // Classified item as it waits in the queue
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MODE_W-1:0]  mode_word;
        logic               blank;
    } vfd_job_t;

    // Map the clock mode to its indicator bits
    function automatic logic [MODE_W-1:0] mode_word(input logic [MODE_W-1:0] mode);
        logic [MODE_W-1:0] bits;
        unique case (mode)
            2'd0:    bits = 2'd0;
            2'd1:    bits = 2'd3;
            2'd2:    bits = 2'd2;
            2'd3:    bits = 2'd1;
            default: bits = 2'd0;
        endcase
        return bits;
    endfunction

    // Active-low grid pattern for one digit, masked to the digit width
    function automatic logic [FRAME_W-1:0] grid_word(input logic [ENTRY_W-1:0] entry);
        logic [15:0] pattern;
        case (entry)
            4'd0:    pattern = 16'hFFFD;
            4'd1:    pattern = 16'hFBFF;
            4'd2:    pattern = 16'hFDFF;
            4'd3:    pattern = 16'hFEFF;
            4'd4:    pattern = 16'hFF7F;
            4'd5:    pattern = 16'hFFBF;
            4'd6:    pattern = 16'hFFDF;
            4'd7:    pattern = 16'hFFEF;
            4'd8:    pattern = 16'hFFF7;
            4'd9:    pattern = 16'hFFFB;
            default: pattern = 16'hFFFF;
        endcase
        return FRAME_W'(pattern & DIGIT_MASK);
    endfunction

endpackage

`default_nettype wire

// ----- src/vfd_front.sv -----
`default_nettype none

module vfd_front
    import vfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire vfd_in_t  src_item,
    output logic          job_valid,
    input  wire logic     job_pop,
    output vfd_job_t      job
);

    vfd_job_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push;
    vfd_job_t              job_in;

    // Classify the incoming item
    always_comb
    begin
        job_in.value     = src_item.display_value;
        job_in.mode_word = mode_word(src_item.mode_code);
        job_in.blank     = src_item.blank;
    end

    // Stall while the queue is full
    assign src_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push      = src_valid && !src_stall;
    assign job_valid = (count_reg != '0);
    assign job       = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (job_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !job_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && job_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the classified item in its slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

`default_nettype wire

// ----- src/vfd_back.sv -----
`default_nettype none

module vfd_back
    import vfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_valid,
    output logic           job_pop,
    input  wire vfd_job_t  job,
    output logic           dst_valid,
    input  wire logic      dst_stall,
    output vfd_out_t       dst_item
);

    logic                  busy_reg, busy_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic                  blank_reg, blank_next;
    logic                  out_valid_reg, out_valid_next;
    vfd_out_t              out_reg, out_next;
    logic                  advance;
    logic [PROD_W-1:0]     product;
    logic [QUOT_W-1:0]     quot;
    logic [VALUE_W-1:0]    tenfold;
    logic [VALUE_W-1:0]    rem_full;
    logic [ENTRY_W-1:0]    entry;
    logic                  last_digit;

    // Split off the low decimal digit
    assign product  = PROD_W'(value_reg) * PROD_W'(RECIP);
    assign quot     = product[PROD_W-1:RECIP_SHIFT];
    assign tenfold  = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
    assign rem_full = value_reg - tenfold;
    assign entry    = blank_reg ? BLANK_ENTRY : rem_full[ENTRY_W-1:0];

    assign last_digit = (idx_reg == IDX_W'(DIGIT_COUNT - 1));
    assign advance    = !out_valid_reg || !dst_stall;
    assign job_pop    = advance && !busy_reg && job_valid;

    // Sequence the mode word, then one digit word per cycle while the output is not stalled
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        blank_next     = blank_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            if (busy_reg)
            begin
                out_valid_next       = 1'b1;
                out_next.frame_word  = grid_word(entry);
                out_next.word_length = WORD_LEN_DIGIT;
                out_next.last_word   = last_digit;
                value_next           = VALUE_W'(quot);
                idx_next             = last_digit ? '0 : idx_reg + 1'b1;
                busy_next            = !last_digit;
            end
            else if (job_valid)
            begin
                out_valid_next       = 1'b1;
                out_next.frame_word  = FRAME_W'(job.mode_word);
                out_next.word_length = WORD_LEN_MODE;
                out_next.last_word   = 1'b0;
                value_next           = job.value;
                blank_next           = job.blank;
                idx_next             = '0;
                busy_next            = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the working value and the output word
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        blank_reg <= blank_next;
        out_reg   <= out_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

endmodule

`default_nettype wire

// ----- src/vfd_digit_frame_serializer_unit.sv -----
// Channel   Direction  Handshake            Payload
// src       in         src_valid/src_stall  vfd_in_t  (display_value, mode_code, blank)
// dst       out        dst_valid/dst_stall  vfd_out_t (frame_word, word_length, last_word)
//
// Each item gives seven words, one per cycle while dst does not stall: the mode word, then six digit words.
// A steady stream is paced by the back end, which sends the words of one item at a time.
// A two-entry job queue takes new items while a frame is still going out.
// Reset clears the queue count, the word sequencer and the output valid.
// A dst stall holds the output word; src stalls only when the queue is full.
`default_nettype none

module vfd_digit_frame_serializer_unit
    import vfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire vfd_in_t  src_item,
    output logic          dst_valid,
    input  wire logic     dst_stall,
    output vfd_out_t      dst_item
);

    logic      job_valid;
    logic      job_pop;
    vfd_job_t  job;

    vfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    vfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

`ifndef SYNTHESIS
    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> job_valid)
        else $error("job popped from empty queue");

    // A full queue always offers a job to the back end
    assert property (@(posedge clk) disable iff (!rst_n) src_stall |-> job_valid)
        else $error("queue full but no job offered");

    // The end-of-frame word is a digit word
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_item.last_word) |-> (dst_item.word_length == WORD_LEN_DIGIT))
        else $error("last word is not a digit word");

    // After the end-of-frame word leaves, the next word is a mode word or nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_stall && dst_item.last_word) |=>
        (!dst_valid || dst_item.word_length == WORD_LEN_MODE))
        else $error("frame did not restart with a mode word");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_vfd_digit_frame_serializer_unit.sv -----
`timescale 1ns / 1ps

module tb_vfd_digit_frame_serializer_unit;
    import vfd_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 30;

    // Mode indicator bits, indexed by mode code
    localparam logic [3:0][1:0] MODE_INDICATOR = {2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [LEN_W-1:0] MODE_WORD_LEN = 4'd2;

    // Active-low grid patterns, indexed by table entry (blank entry on top)
    localparam logic [10:0][15:0] GRID_TABLE = {
        16'hFFFF, 16'hFFFB, 16'hFFF7, 16'hFFEF, 16'hFFDF, 16'hFFBF,
        16'hFF7F, 16'hFEFF, 16'hFDFF, 16'hFBFF, 16'hFFFD
    };
    localparam logic [15:0] DIGIT_KEEP = 16'((32'd1 << DIGIT_BITS) - 32'd1);

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    vfd_in_t  src_item = '0;
    logic     dst_valid;
    logic     dst_stall = 1'b0;
    vfd_out_t dst_item;

    vfd_in_t  pending_items[$];
    vfd_out_t words_due[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       src_gap = 0;
    int       src_quiet = 0;
    int       stall_left = 0;
    int       dst_quiet = 0;
    vfd_out_t want;

    vfd_digit_frame_serializer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Expected words of one frame: mode word, then digit words ones first
    function automatic void expand_frame(input vfd_in_t item);
        logic [VALUE_W-1:0] rest;
        logic [ENTRY_W-1:0] entry;
        vfd_out_t           word;
        rest = item.display_value;
        word.frame_word  = FRAME_W'(MODE_INDICATOR[item.mode_code]);
        word.word_length = MODE_WORD_LEN;
        word.last_word   = 1'b0;
        words_due.push_back(word);
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            entry = item.blank ? BLANK_ENTRY : ENTRY_W'(rest % 10);
            rest  = VALUE_W'(rest / 10);
            word.frame_word  = FRAME_W'(GRID_TABLE[entry] & DIGIT_KEEP);
            word.word_length = LEN_W'(DIGIT_BITS);
            word.last_word   = (k == DIGIT_COUNT - 1);
            words_due.push_back(word);
        end
    endfunction

    // Idle length: mostly none or short, a few long, with quiet stretches
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_item(input logic [VALUE_W-1:0] value,
                                       input logic [MODE_W-1:0] mode, input logic blank);
        vfd_in_t item;
        item.display_value = value;
        item.mode_code     = mode;
        item.blank         = blank;
        pending_items.push_back(item);
    endfunction

    // Driver: present the next pending item, hold it while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                expand_frame(src_item);
            if (!src_valid || !src_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    src_item  <= pending_items.pop_front();
                    src_valid <= 1'b1;
                    src_gap    = pick_gap(src_quiet);
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted word, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                if (words_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h len %0d last %b",
                             $time, dst_item.frame_word, dst_item.word_length,
                             dst_item.last_word);
                    mismatches++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (dst_item.frame_word !== want.frame_word
                        || dst_item.word_length !== want.word_length
                        || dst_item.last_word !== want.last_word)
                    begin
                        $display("%0t: mismatch: expected %h len %0d last %b, %s %h len %0d last %b",
                                 $time, want.frame_word, want.word_length, want.last_word,
                                 "actual", dst_item.frame_word, dst_item.word_length,
                                 dst_item.last_word);
                        mismatches++;
                    end
                end
            end
            if (stall_left == 0)
                stall_left = pick_gap(dst_quiet);
            dst_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [VALUE_W-1:0] value;

        // Directed: field extremes, every digit, every mode, blanking, oversize values
        queue_item(20'd0,       2'd0, 1'b0);
        queue_item(20'd999999,  2'd1, 1'b0);
        queue_item(20'd123456,  2'd2, 1'b0);
        queue_item(20'd789012,  2'd3, 1'b0);
        queue_item(20'd100000,  2'd0, 1'b0);
        queue_item(20'd654321,  2'd1, 1'b0);
        queue_item(20'd999999,  2'd0, 1'b1);
        queue_item(20'd0,       2'd1, 1'b1);
        queue_item(20'd345678,  2'd2, 1'b1);
        queue_item(20'd120000,  2'd3, 1'b1);
        queue_item(20'd1000000, 2'd2, 1'b0);
        queue_item(20'hFFFFF,   2'd3, 1'b0);
        queue_item(20'h55555,   2'd1, 1'b0);
        queue_item(20'hAAAAA,   2'd2, 1'b0);
        queue_item(20'hFFFFF,   2'd0, 1'b1);
        queue_item(20'd9,       2'd3, 1'b0);
        queue_item(20'd235959,  2'd0, 1'b0);

        // Random: mostly valid display values, some over the decimal range
        repeat (RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
                value = VALUE_W'($urandom_range(0, 999999));
            else
                value = VALUE_W'($urandom_range(0, 20'hFFFFF));
            queue_item(value, MODE_W'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Drain, then let any stray words show up
        while (pending_items.size() != 0 || src_valid || words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- vfd_digit_frame_serializer_unit.f -----
src/vfd_pkg.sv
src/vfd_front.sv
src/vfd_back.sv
src/vfd_digit_frame_serializer_unit.sv
dv/tb_vfd_digit_frame_serializer_unit.sv
